### hw/rtl/lpfd_pkg.sv
// Package for the length-prefixed frame deframer.
// Holds the header layout, result codes, phase type and result record.
// No dependencies; the core and lpfd_csr import it.
package lpfd_pkg;

   // Header layout: length(2) sequence(4) id(4) reliable(1) reserved(1)
   localparam int unsigned HEADER_BYTES = 12;
   localparam int unsigned COUNT_W      = 16;
   localparam int unsigned POS_W        = 4;

   localparam logic [POS_W-1:0] POS_LEN_0    = 4'd0;
   localparam logic [POS_W-1:0] POS_LEN_1    = 4'd1;
   localparam logic [POS_W-1:0] POS_SEQ_0    = 4'd2;
   localparam logic [POS_W-1:0] POS_SEQ_1    = 4'd3;
   localparam logic [POS_W-1:0] POS_SEQ_2    = 4'd4;
   localparam logic [POS_W-1:0] POS_SEQ_3    = 4'd5;
   localparam logic [POS_W-1:0] POS_ID_0     = 4'd6;
   localparam logic [POS_W-1:0] POS_ID_1     = 4'd7;
   localparam logic [POS_W-1:0] POS_ID_2     = 4'd8;
   localparam logic [POS_W-1:0] POS_ID_3     = 4'd9;
   localparam logic [POS_W-1:0] POS_RELIABLE = 4'd10;

   // Result kinds and error codes
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic ERR_UNDERFLOW = 1'b0;
   localparam logic ERR_OVERFLOW  = 1'b1;

   // Register file
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic        REG_MAX_FRAME = 1'b0;
   localparam logic [15:0] MAX_FRAME_RESET = 16'd8192;

   typedef enum logic [1:0] {
      PHASE_HEADER,
      PHASE_PAYLOAD,
      PHASE_HALTED
   } phase_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [15:0] frame_length;
      logic [31:0] sequence_number;
      logic [31:0] message_id;
      logic [7:0]  reliable_flag;
      logic [7:0]  payload_byte;
      logic        last_of_frame;
      logic        error_code;
   } result_type;

endpackage

### hw/rtl/lpfd_req_if.sv
// Input channel of the deframer: one stream byte per transaction.
// Depends on nothing.
interface lpfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

### hw/rtl/lpfd_rsp_if.sv
// Result channel of the deframer: header, payload or error record.
// Depends on nothing.
interface lpfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] frame_length;
   logic [31:0] sequence_number;
   logic [31:0] message_id;
   logic [7:0]  reliable_flag;
   logic [7:0]  payload_byte;
   logic        last_of_frame;
   logic        error_code;

   modport source (
      output valid, output result_kind, output frame_length, output sequence_number,
      output message_id, output reliable_flag, output payload_byte,
      output last_of_frame, output error_code, input ready
   );
   modport sink (
      input valid, input result_kind, input frame_length, input sequence_number,
      input message_id, input reliable_flag, input payload_byte,
      input last_of_frame, input error_code, output ready
   );
endinterface

### hw/rtl/length_prefixed_frame_deframer_core.sv
// Top level of the length-prefixed frame deframer.
// Depends on lpfd_pkg, lpfd_req_if, lpfd_rsp_if and lpfd_csr.
//
//   channel   direction  width    carries
//   req_if    in         8        one stream byte per transaction
//   rsp_if    out        100      header / payload / error record
//   csr_*     in/out     32       APB write/read of max_frame_bytes
//
// One byte is taken per cycle when not stalled; any result it makes is registered.
// The limit is the single result register: a byte that makes a result waits only
// while that register is full and not being taken; header bytes that make no
// result and bytes after a halt are taken regardless of rsp_if.ready.
// Synchronous reset returns to header phase, clears the halt, sets capacity 8192.
module length_prefixed_frame_deframer_core import lpfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lpfd_req_if.sink              req_if,
   lpfd_rsp_if.source            rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [COUNT_W-1:0] HDR_LEN  = COUNT_W'(HEADER_BYTES);
   localparam logic [COUNT_W-1:0] HDR_LAST = COUNT_W'(HEADER_BYTES - 1);

   logic [15:0]        max_frame_bytes;

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        length_ff, length_in;
   logic [31:0]        seq_ff, seq_in;
   logic [31:0]        id_ff, id_in;
   logic [7:0]         rel_ff, rel_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   logic               header_last;
   logic               makes_result;
   logic               out_free;
   logic               accept;
   logic [COUNT_W-1:0] count_inc;
   logic               payload_last;
   logic               len_under;
   logic               len_over;
   logic               len_only;
   logic [7:0]         in_byte;

   lpfd_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (csr_psel),
      .penable         (csr_penable),
      .pwrite          (csr_pwrite),
      .paddr           (csr_paddr),
      .pwdata          (csr_pwdata),
      .prdata          (csr_prdata),
      .pready          (csr_pready),
      .max_frame_bytes (max_frame_bytes)
   );

   // Handshake: stall only bytes that produce a result while the output is full
   assign in_byte      = req_if.stream_byte;
   assign header_last  = (phase_ff == PHASE_HEADER) && (count_ff == HDR_LAST);
   assign makes_result = header_last || (phase_ff == PHASE_PAYLOAD);
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !makes_result || out_free;
   assign accept       = req_if.valid && req_if.ready;

   // Length checks and payload position
   assign count_inc    = count_ff + COUNT_W'(1);
   assign payload_last = (count_inc >= length_ff);
   assign len_under    = (length_ff < HDR_LEN);
   assign len_over     = (length_ff >= max_frame_bytes);
   assign len_only     = (length_ff == HDR_LEN);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PHASE_HEADER: begin
            if (header_last) begin
               if (len_under || len_over) begin
                  phase_in = PHASE_HALTED;
               end else if (!len_only) begin
                  phase_in = PHASE_PAYLOAD;
               end
            end
         end
         PHASE_PAYLOAD: begin
            if (payload_last) begin
               phase_in = PHASE_HEADER;
            end
         end
         PHASE_HALTED: begin
            phase_in = PHASE_HALTED;
         end
         default: begin
            phase_in = PHASE_HALTED;
         end
      endcase
   end

   // Counter, header capture and result record
   always_comb begin
      count_in  = count_ff;
      length_in = length_ff;
      seq_in    = seq_ff;
      id_in     = id_ff;
      rel_in    = rel_ff;

      rsp_in.result_kind     = KIND_HEADER;
      rsp_in.frame_length    = length_ff;
      rsp_in.sequence_number = seq_ff;
      rsp_in.message_id      = id_ff;
      rsp_in.reliable_flag   = rel_ff;
      rsp_in.payload_byte    = '0;
      rsp_in.last_of_frame   = 1'b0;
      rsp_in.error_code      = ERR_UNDERFLOW;

      case (phase_ff)
         PHASE_HEADER: begin
            // Store byte at its header position; reserved byte is dropped
            case (count_ff[POS_W-1:0])
               POS_LEN_0:    length_in[7:0]  = in_byte;
               POS_LEN_1:    length_in[15:8] = in_byte;
               POS_SEQ_0:    seq_in[7:0]     = in_byte;
               POS_SEQ_1:    seq_in[15:8]    = in_byte;
               POS_SEQ_2:    seq_in[23:16]   = in_byte;
               POS_SEQ_3:    seq_in[31:24]   = in_byte;
               POS_ID_0:     id_in[7:0]      = in_byte;
               POS_ID_1:     id_in[15:8]     = in_byte;
               POS_ID_2:     id_in[23:16]    = in_byte;
               POS_ID_3:     id_in[31:24]    = in_byte;
               POS_RELIABLE: rel_in          = in_byte;
               default: begin
               end
            endcase
            count_in = count_inc;
            if (header_last) begin
               if (len_under) begin
                  rsp_in.result_kind = KIND_ERROR;
                  rsp_in.error_code  = ERR_UNDERFLOW;
               end else if (len_over) begin
                  rsp_in.result_kind = KIND_ERROR;
                  rsp_in.error_code  = ERR_OVERFLOW;
               end else if (len_only) begin
                  // Header-only message closes right here
                  rsp_in.last_of_frame = 1'b1;
                  count_in             = '0;
               end
            end
         end
         PHASE_PAYLOAD: begin
            rsp_in.result_kind   = KIND_PAYLOAD;
            rsp_in.payload_byte  = in_byte;
            rsp_in.last_of_frame = payload_last;
            count_in             = payload_last ? '0 : count_inc;
         end
         PHASE_HALTED: begin
         end
         default: begin
         end
      endcase
   end

   // Output register: load on a result, clear when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && makes_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_HEADER;
         count_ff     <= '0;
         length_ff    <= '0;
         seq_ff       <= '0;
         id_ff        <= '0;
         rel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            length_ff <= length_in;
            seq_ff    <= seq_in;
            id_ff     <= id_in;
            rel_ff    <= rel_in;
         end
      end
   end

   // Result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept && makes_result) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.result_kind     = rsp_ff.result_kind;
   assign rsp_if.frame_length    = rsp_ff.frame_length;
   assign rsp_if.sequence_number = rsp_ff.sequence_number;
   assign rsp_if.message_id      = rsp_ff.message_id;
   assign rsp_if.reliable_flag   = rsp_ff.reliable_flag;
   assign rsp_if.payload_byte    = rsp_ff.payload_byte;
   assign rsp_if.last_of_frame   = rsp_ff.last_of_frame;
   assign rsp_if.error_code      = rsp_ff.error_code;

endmodule

### hw/rtl/lpfd_csr.sv
// APB-style register block of the deframer: holds max_frame_bytes.
// Depends on lpfd_pkg.
module lpfd_csr import lpfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [15:0]           max_frame_bytes
);

   logic [15:0] max_frame_ff;
   logic [15:0] max_frame_in;
   logic        reg_index;
   logic        write_hit;

   // Word index; registers sit at byte address 4*i
   assign reg_index = paddr[2];
   assign write_hit = psel && penable && pwrite && (reg_index == REG_MAX_FRAME);

   always_comb begin
      max_frame_in = max_frame_ff;
      if (write_hit) begin
         max_frame_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= MAX_FRAME_RESET;
      end else begin
         max_frame_ff <= max_frame_in;
      end
   end

   // Read back; unmapped index reads zero
   always_comb begin
      prdata = '0;
      if (reg_index == REG_MAX_FRAME) begin
         prdata = {{(CSR_DATA_W-16){1'b0}}, max_frame_ff};
      end
   end

   assign pready          = 1'b1;
   assign max_frame_bytes = max_frame_ff;

endmodule
